// ===== hw/rtl/dmsrt_pkg.sv =====
package dmsrt_pkg;

   localparam int SLOT_COUNT_DEF = 4096;
   localparam int MATE_BAND_DEF  = 1000;

   localparam int KEY_W   = 64;
   localparam int PAY_W   = 42;
   localparam int ENTRY_W = KEY_W + PAY_W;
   localparam int MATE_W  = 15;

   localparam logic [MATE_W-1:0] MATE_RESET = 15'd32000;

   localparam logic [1:0] MODE_PROBE = 2'd0;
   localparam logic [1:0] MODE_STORE = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   localparam logic [1:0] FLAG_NONE  = 2'd0;
   localparam logic [1:0] FLAG_EXACT = 2'd1;
   localparam logic [1:0] FLAG_UPPER = 2'd2;
   localparam logic [1:0] FLAG_LOWER = 2'd3;

   typedef struct packed {
      logic [1:0]         mode;
      logic [KEY_W-1:0]   position_key;
      logic [7:0]         search_depth;
      logic signed [15:0] window_low;
      logic signed [15:0] window_high;
      logic [7:0]         root_distance;
      logic signed [15:0] new_score;
      logic [1:0]         bound_kind;
      logic [15:0]        new_move;
   } req_payload_type;

   typedef struct packed {
      logic               hit;
      logic signed [15:0] found_score;
      logic [15:0]        move_hint;
   } rsp_payload_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [7:0]         depth;
      logic [1:0]         flag;
      logic signed [15:0] score;
      logic [15:0]        move;
   } entry_type;

   typedef struct packed {
      logic take;
      logic read_req;
      logic rem_step;
      logic read_rem;
      logic sweep;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic req_clear;
      logic slot_direct;
      logic rem_last;
      logic sweep_last;
      logic rsp_free;
   } status_type;

   // to_ply: root-relative to ply-relative (store), else the reverse (read)
   function automatic logic signed [15:0] mate_adjust(
      input logic signed [15:0] score,
      input logic [7:0]         ply,
      input logic [MATE_W-1:0]  mate,
      input logic [MATE_W-1:0]  band,
      input logic               to_ply
   );
      logic signed [17:0] s;
      logic signed [17:0] p;
      logic signed [17:0] th_hi;
      logic signed [17:0] th_lo;
      logic signed [17:0] sum;
      s     = $signed({{2{score[15]}}, score});
      p     = $signed({10'd0, ply});
      th_hi = $signed({3'd0, mate}) - $signed({3'd0, band});
      th_lo = -th_hi;
      if (s >= th_hi) begin
         sum = to_ply ? s + p : s - p;
      end else if (s <= th_lo) begin
         sum = to_ply ? s - p : s + p;
      end else begin
         sum = s;
      end
      if (sum > 18'sd32767) begin
         sum = 18'sd32767;
      end else if (sum < -18'sd32768) begin
         sum = -18'sd32768;
      end
      return sum[15:0];
   endfunction

endpackage

// ===== hw/rtl/dmsrt_ram.sv =====
module dmsrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/dmsrt_ctrl.sv =====
module dmsrt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  dmsrt_pkg::status_type st,
   output dmsrt_pkg::cmd_type    cmd
);
   import dmsrt_pkg::*;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_INDEX,
      ST_CLEAR,
      ST_EVAL
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            cmd.sweep = 1'b1;
            if (st.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid && ready_ff) begin
               cmd.take = 1'b1;
               if (st.req_clear) begin
                  state_in = ST_CLEAR;
               end else if (st.slot_direct) begin
                  cmd.read_req = 1'b1;
                  state_in     = ST_EVAL;
               end else begin
                  state_in = ST_INDEX;
               end
            end
         end
         ST_INDEX: begin
            // one key nibble per cycle into the slot remainder
            cmd.rem_step = 1'b1;
            if (st.rem_last) begin
               cmd.read_rem = 1'b1;
               state_in     = ST_EVAL;
            end
         end
         ST_CLEAR: begin
            cmd.sweep = 1'b1;
            if (st.sweep_last) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (st.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
      ready_in = (state_in == ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready = ready_ff;

endmodule

// ===== hw/rtl/dmsrt_dpath.sv =====
module dmsrt_dpath #(
   parameter int SLOT_COUNT = dmsrt_pkg::SLOT_COUNT_DEF,
   parameter int MATE_BAND  = dmsrt_pkg::MATE_BAND_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  dmsrt_pkg::req_payload_type      req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output dmsrt_pkg::rsp_payload_type      rsp_payload,
   input  logic                            csr_we,
   input  logic [dmsrt_pkg::MATE_W-1:0]    csr_wdata,
   input  dmsrt_pkg::cmd_type              cmd,
   output dmsrt_pkg::status_type           st
);
   import dmsrt_pkg::*;

   localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam bit SLOT_DIRECT = (SLOT_COUNT > 1) && ((SLOT_COUNT & (SLOT_COUNT - 1)) == 0);
   localparam logic [AW-1:0]     LAST_SLOT = AW'(SLOT_COUNT - 1);
   localparam logic [MATE_W-1:0] BAND      = MATE_W'(MATE_BAND);
   localparam int DIG_W  = 4;
   localparam int DIGITS = KEY_W / DIG_W;
   localparam int CNT_W  = $clog2(DIGITS);

   req_payload_type   item_ff;
   logic [MATE_W-1:0] mate_ff;
   logic [AW-1:0]     rem_ff, rem_in;
   logic [KEY_W-1:0]  keysh_ff;
   logic [CNT_W-1:0]  dig_cnt_ff;
   logic [AW-1:0]     sweep_ff;
   logic [AW-1:0]     slot_ff;
   logic              rsp_valid_ff;
   rsp_payload_type   rsp_ff, rsp_in;

   logic [AW+DIG_W-1:0]  rem_x;
   logic [AW+DIG_W-1:0]  rem_sub;
   logic [AW-1:0]        rd_addr;
   logic                 rd_en;
   logic [ENTRY_W-1:0]   rd_data;
   entry_type            rd_entry;
   entry_type            wr_entry;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic                 key_match;
   logic                 replace;
   logic signed [15:0]   read_score;

   // key mod slot count, one nibble per step msb first: r = 16r + digit, then the
   // largest multiple of the count (up to fifteen) that fits is taken off
   always_comb begin
      rem_x   = {rem_ff, keysh_ff[KEY_W-1 -: DIG_W]};
      rem_sub = '0;
      for (int j = 1; j < (1 << DIG_W); j++) begin
         if (rem_x >= (AW + DIG_W)'(j * SLOT_COUNT)) begin
            rem_sub = (AW + DIG_W)'(j * SLOT_COUNT);
         end
      end
      rem_in = AW'(rem_x - rem_sub);
   end

   assign rd_en   = cmd.read_req | cmd.read_rem;
   assign rd_addr = cmd.read_rem ? rem_in : req_payload.position_key[AW-1:0];

   assign rd_entry   = entry_type'(rd_data);
   assign key_match  = (rd_entry.key == item_ff.position_key);
   assign replace    = !key_match || (item_ff.search_depth >= rd_entry.depth);
   assign read_score = mate_adjust(rd_entry.score, item_ff.root_distance, mate_ff, BAND, 1'b0);

   always_comb begin
      wr_entry.key   = item_ff.position_key;
      wr_entry.depth = item_ff.search_depth;
      wr_entry.flag  = item_ff.bound_kind;
      wr_entry.score = mate_adjust(item_ff.new_score, item_ff.root_distance, mate_ff, BAND,
                                   1'b1);
      wr_entry.move  = item_ff.new_move;
      if (cmd.sweep) begin
         wr_entry = '0;
      end
   end

   assign wr_en   = cmd.sweep | (cmd.finish & (item_ff.mode == MODE_STORE) & replace);
   assign wr_addr = cmd.sweep ? sweep_ff : slot_ff;

   always_comb begin
      rsp_in = '0;
      if (item_ff.mode == MODE_PROBE && key_match) begin
         rsp_in.move_hint = rd_entry.move;
         if (rd_entry.depth >= item_ff.search_depth) begin
            case (rd_entry.flag)
               FLAG_EXACT: begin
                  rsp_in.hit         = 1'b1;
                  rsp_in.found_score = read_score;
               end
               FLAG_UPPER: begin
                  if (read_score <= item_ff.window_low) begin
                     rsp_in.hit         = 1'b1;
                     rsp_in.found_score = item_ff.window_low;
                  end
               end
               FLAG_LOWER: begin
                  if (read_score >= item_ff.window_high) begin
                     rsp_in.hit         = 1'b1;
                     rsp_in.found_score = item_ff.window_high;
                  end
               end
               default: begin
                  rsp_in.hit = 1'b0;
               end
            endcase
         end
      end
   end

   dmsrt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOT_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         item_ff  <= req_payload;
         keysh_ff <= req_payload.position_key;
      end else if (cmd.rem_step) begin
         keysh_ff <= keysh_ff << DIG_W;
      end
      if (rd_en) begin
         slot_ff <= rd_addr;
      end
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mate_ff      <= MATE_RESET;
         rem_ff       <= '0;
         dig_cnt_ff   <= '0;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            mate_ff <= csr_wdata;
         end
         if (cmd.take) begin
            rem_ff     <= '0;
            dig_cnt_ff <= '0;
         end else if (cmd.rem_step) begin
            rem_ff     <= rem_in;
            dig_cnt_ff <= dig_cnt_ff + 1'b1;
         end
         if (cmd.sweep) begin
            sweep_ff <= st.sweep_last ? '0 : sweep_ff + 1'b1;
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign st.req_clear   = (req_payload.mode == MODE_CLEAR);
   assign st.slot_direct = SLOT_DIRECT;
   assign st.rem_last    = (dig_cnt_ff == CNT_W'(DIGITS - 1));
   assign st.sweep_last  = (sweep_ff == LAST_SLOT);
   assign st.rsp_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== hw/rtl/direct_mapped_search_result_table.sv =====
// probe, store or unused mode: the slot is read, then the result is registered once
//   output is free; a non power-of-two slot count first takes key mod count by nibble
// one item at a time: a new one is taken only after the read then update of its slot
// clear: one slot per cycle over the whole table, then the result
// reset: synchronous; a zeroing sweep over every slot runs before the first accept
module direct_mapped_search_result_table #(
   parameter int SLOT_COUNT = dmsrt_pkg::SLOT_COUNT_DEF,
   parameter int MATE_BAND  = dmsrt_pkg::MATE_BAND_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  dmsrt_pkg::req_payload_type   req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output dmsrt_pkg::rsp_payload_type   rsp_payload,
   input  logic                         csr_we,
   input  logic [dmsrt_pkg::MATE_W-1:0] csr_wdata
);
   import dmsrt_pkg::*;

   cmd_type    cmd;
   status_type st;

   dmsrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   dmsrt_dpath #(
      .SLOT_COUNT (SLOT_COUNT),
      .MATE_BAND  (MATE_BAND)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .st          (st)
   );

   // the zeroing sweep blocks input right after reset
   a_reset_blocks: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("input ready right after reset");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second beat taken while one is in flight");

   a_miss_score_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.hit |-> rsp_payload.found_score == 16'sd0)
      else $error("score returned without a hit");

   a_finish_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> st.rsp_free)
      else $error("result loaded over an untaken beat");

endmodule

// ===== test/direct_mapped_search_result_table_tb.sv =====
module direct_mapped_search_result_table_tb;
   import dmsrt_pkg::*;

   localparam int SLOTS = SLOT_COUNT_DEF;
   localparam int BAND = MATE_BAND_DEF;
   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASE_ITEMS = 113;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [63:0] KEY_TOP = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] KEY_ALIAS = 64'h8000_0000_0000_0FFF;
   localparam logic [63:0] KEY_LOW = 64'h0123_4567_89AB_C000;

   typedef struct {
      req_payload_type item;
      bit              typed;
      rsp_payload_type want;
   } plan_row_type;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_payload;
   logic            csr_we;
   logic [MATE_W-1:0] csr_wdata;

   // predicted table contents
   logic [63:0]        tab_key   [SLOTS];
   logic [7:0]         tab_depth [SLOTS];
   logic [1:0]         tab_flag  [SLOTS];
   logic signed [15:0] tab_score [SLOTS];
   logic [15:0]        tab_move  [SLOTS];
   logic [MATE_W-1:0]  mate_cfg;

   rsp_payload_type awaited_results[$];
   plan_row_type    plan[$];
   logic [63:0]     key_pool[16];

   int gap_pct;
   int stall_pct;
   int mismatches;
   int cycle_count;
   int n_requests;
   int n_hits;
   int n_clears;

   direct_mapped_search_result_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic signed [15:0] clamp16(input int v);
      if (v > 32767) begin
         v = 32767;
      end else if (v < -32768) begin
         v = -32768;
      end
      return 16'(v);
   endfunction

   // dir +1 makes a mate score ply-relative, -1 brings it back to the root
   function automatic logic signed [15:0] ply_shift(input int score, input int ply,
                                                   input int dir);
      int m;
      int r;
      m = int'(mate_cfg);
      if (score >= m - BAND) begin
         r = score + dir * ply;
      end else if (score <= BAND - m) begin
         r = score - dir * ply;
      end else begin
         r = score;
      end
      return clamp16(r);
   endfunction

   function automatic void wipe_table();
      for (int i = 0; i < SLOTS; i++) begin
         tab_key[i] = '0;
         tab_depth[i] = '0;
         tab_flag[i] = FLAG_NONE;
         tab_score[i] = '0;
         tab_move[i] = '0;
      end
   endfunction

   function automatic rsp_payload_type table_step(input req_payload_type r);
      rsp_payload_type o;
      int slot;
      int s;
      o = '0;
      slot = int'(r.position_key % 64'(SLOTS));
      case (r.mode)
         MODE_PROBE: begin
            if (tab_key[slot] == r.position_key) begin
               o.move_hint = tab_move[slot];
               if (tab_depth[slot] >= r.search_depth) begin
                  s = int'(ply_shift(int'(tab_score[slot]), int'(r.root_distance), -1));
                  if (tab_flag[slot] == FLAG_EXACT) begin
                     o.hit = 1'b1;
                     o.found_score = 16'(s);
                  end else if (tab_flag[slot] == FLAG_UPPER && s <= int'(r.window_low)) begin
                     o.hit = 1'b1;
                     o.found_score = r.window_low;
                  end else if (tab_flag[slot] == FLAG_LOWER && s >= int'(r.window_high)) begin
                     o.hit = 1'b1;
                     o.found_score = r.window_high;
                  end
               end
            end
         end
         MODE_STORE: begin
            if (tab_key[slot] != r.position_key || r.search_depth >= tab_depth[slot]) begin
               tab_key[slot] = r.position_key;
               tab_depth[slot] = r.search_depth;
               tab_flag[slot] = r.bound_kind;
               tab_score[slot] = ply_shift(int'(r.new_score), int'(r.root_distance), 1);
               tab_move[slot] = r.new_move;
            end
         end
         MODE_CLEAR: begin
            wipe_table();
         end
         default: begin
         end
      endcase
      return o;
   endfunction

   function automatic req_payload_type mk_req(
      input logic [1:0] mode, input logic [63:0] key, input logic [7:0] depth,
      input logic signed [15:0] lo, input logic signed [15:0] hi, input logic [7:0] ply,
      input logic signed [15:0] score, input logic [1:0] flag, input logic [15:0] move
   );
      req_payload_type r;
      r.mode = mode;
      r.position_key = key;
      r.search_depth = depth;
      r.window_low = lo;
      r.window_high = hi;
      r.root_distance = ply;
      r.new_score = score;
      r.bound_kind = flag;
      r.new_move = move;
      return r;
   endfunction

   function automatic void add_row(input req_payload_type item, input bit typed);
      plan_row_type row;
      row.item = item;
      row.typed = typed;
      row.want = '0;
      plan.push_back(row);
   endfunction

   function automatic logic signed [15:0] pick_score();
      int m;
      int off;
      int v;
      m = int'(mate_cfg);
      off = int'($urandom_range(0, 6)) - 3;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = int'($urandom_range(0, 65535)) - 32768;
         4: v = m - BAND + off;
         5: v = BAND - m + off;
         6: v = m + off;
         7: v = -m + off;
         8: v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
         default: v = int'($urandom_range(0, 100)) - 50;
      endcase
      return clamp16(v);
   endfunction

   // often lands right around what the slot would read back, to hit the cutoff edges
   function automatic logic signed [15:0] pick_window(input logic [63:0] key,
                                                     input logic [7:0] ply);
      int slot;
      int off;
      int s;
      slot = int'(key % 64'(SLOTS));
      if (tab_key[slot] == key && $urandom_range(0, 99) < 50) begin
         off = int'($urandom_range(0, 2)) - 1;
         s = int'(ply_shift(int'(tab_score[slot]), int'(ply), -1));
         return clamp16(s + off);
      end
      return pick_score();
   endfunction

   function automatic req_payload_type random_request();
      req_payload_type r;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 48) begin
         r.mode = MODE_PROBE;
      end else if (pick < 96) begin
         r.mode = MODE_STORE;
      end else if (pick < 98) begin
         r.mode = MODE_UNUSED;
      end else begin
         r.mode = MODE_CLEAR;
      end
      if ($urandom_range(0, 99) < 85) begin
         r.position_key = key_pool[$urandom_range(0, 15)];
      end else begin
         r.position_key = {$urandom, $urandom};
      end
      pick = $urandom_range(0, 9);
      r.search_depth = (pick < 8) ? 8'($urandom_range(0, 7)) :
                       (pick == 8) ? 8'hFF : 8'($urandom);
      r.root_distance = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 40)) :
                        8'($urandom);
      r.window_low = pick_window(r.position_key, r.root_distance);
      r.window_high = pick_window(r.position_key, r.root_distance);
      r.new_score = pick_score();
      r.bound_kind = 2'($urandom_range(0, 3));
      r.new_move = 16'($urandom);
      return r;
   endfunction

   // groups of four keys share a slot; key 0 sits with the empty-slot pattern
   task automatic refill_keys();
      key_pool[0] = '0;
      for (int i = 1; i < 16; i++) begin
         key_pool[i] = {$urandom, $urandom};
         if (i % 4 != 0) begin
            key_pool[i][11:0] = key_pool[i - i % 4][11:0];
         end
      end
   endtask

   task automatic send_beat(input req_payload_type item, input bit typed,
                            input rsp_payload_type want);
      rsp_payload_type predicted;
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      predicted = table_step(item);
      awaited_results.push_back(typed ? want : predicted);
      n_requests++;
      if (item.mode == MODE_CLEAR) begin
         n_clears++;
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_results.size() != 0);
   endtask

   task automatic set_mate_score(input logic [MATE_W-1:0] v);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      mate_cfg = v;
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected result beat: hit=%0b score=%0d move=%h",
                           rsp_payload.hit, rsp_payload.found_score, rsp_payload.move_hint);
               end
            end else begin
               want = awaited_results.pop_front();
               if (rsp_payload.hit !== want.hit || rsp_payload.found_score !== want.found_score
                   || rsp_payload.move_hint !== want.move_hint) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display({"mismatch: expected hit=%0b score=%0d move=%h,",
                               " got hit=%0b score=%0d move=%h"},
                              want.hit, want.found_score, want.move_hint, rsp_payload.hit,
                              rsp_payload.found_score, rsp_payload.move_hint);
                  end
               end
               if (rsp_payload.hit === 1'b1) begin
                  n_hits++;
               end
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  awaited_results.size());
         $display("direct_mapped_search_result_table_tb: done, errors");
         $finish;
      end
   end

   initial begin
      logic [MATE_W-1:0] mate_plan[6];
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      n_requests = 0;
      n_clears = 0;
      gap_pct = 10;
      stall_pct = 59;
      mate_cfg = MATE_RESET;
      wipe_table();
      mate_plan = '{15'd32767, 15'd0, 15'd1000, 15'($urandom_range(0, 32767)), 15'd500,
                    15'd32000};

      // empty slot, unused mode, saturating mate scores, replacement, each cutoff kind
      add_row(mk_req(MODE_PROBE, '0, 8'd0, 16'sd0, 16'sd0, 8'd0, 16'sd0, FLAG_NONE, 16'h0), 1);
      add_row(mk_req(MODE_UNUSED, '1, 8'hFF, -16'sd1, -16'sd1, 8'hFF, -16'sd1, FLAG_LOWER,
                     16'hFFFF), 1);
      add_row(mk_req(MODE_STORE, KEY_TOP, 8'hFF, 16'sd0, 16'sd0, 8'hFF, 16'sd32767, FLAG_EXACT,
                     16'hFFFF), 1);
      add_row(mk_req(MODE_PROBE, KEY_TOP, 8'hFF, 16'sd0, 16'sd0, 8'hFF, 16'sd0, FLAG_NONE, 16'h0), 0);
      add_row(mk_req(MODE_PROBE, KEY_TOP, 8'd0, -16'sd32768, 16'sd32767, 8'd0, 16'sd0, FLAG_NONE,
                     16'h0), 0);
      add_row(mk_req(MODE_STORE, KEY_TOP, 8'd10, 16'sd0, 16'sd0, 8'd0, 16'sd5, FLAG_EXACT,
                     16'h1234), 1);
      add_row(mk_req(MODE_PROBE, KEY_TOP, 8'd0, 16'sd0, 16'sd0, 8'd0, 16'sd0, FLAG_NONE, 16'h0), 0);
      add_row(mk_req(MODE_STORE, KEY_ALIAS, 8'd0, 16'sd0, 16'sd0, 8'd3, -16'sd500, FLAG_UPPER,
                     16'h0BAD), 1);
      add_row(mk_req(MODE_PROBE, KEY_ALIAS, 8'd0, -16'sd500, 16'sd0, 8'd3, 16'sd0, FLAG_NONE,
                     16'h0), 0);
      add_row(mk_req(MODE_PROBE, KEY_ALIAS, 8'd0, -16'sd501, 16'sd0, 8'd3, 16'sd0, FLAG_NONE,
                     16'h0), 0);
      add_row(mk_req(MODE_STORE, KEY_ALIAS, 8'd3, 16'sd0, 16'sd0, 8'd0, 16'sd200, FLAG_LOWER,
                     16'h0042), 1);
      add_row(mk_req(MODE_PROBE, KEY_ALIAS, 8'd3, 16'sd0, 16'sd200, 8'd0, 16'sd0, FLAG_NONE,
                     16'h0), 0);
      add_row(mk_req(MODE_PROBE, KEY_ALIAS, 8'd4, 16'sd0, -16'sd32768, 8'd0, 16'sd0, FLAG_NONE,
                     16'h0), 0);
      add_row(mk_req(MODE_STORE, KEY_LOW, 8'd7, 16'sd0, 16'sd0, 8'd0, 16'sd100, FLAG_NONE,
                     16'h7777), 1);
      add_row(mk_req(MODE_PROBE, KEY_LOW, 8'd0, 16'sd32767, -16'sd32768, 8'd0, 16'sd0, FLAG_NONE,
                     16'h0), 0);
      add_row(mk_req(MODE_STORE, '0, 8'd1, 16'sd0, 16'sd0, 8'd200, -16'sd32768, FLAG_EXACT,
                     16'h0001), 1);
      add_row(mk_req(MODE_PROBE, '0, 8'd1, 16'sd0, 16'sd0, 8'd200, 16'sd0, FLAG_NONE, 16'h0), 0);
      add_row(mk_req(MODE_STORE, KEY_TOP, 8'hFF, 16'sd0, 16'sd0, 8'd5, 16'sd31000, FLAG_EXACT,
                     16'h5555), 1);
      add_row(mk_req(MODE_PROBE, KEY_TOP, 8'hFF, 16'sd0, 16'sd0, 8'd7, 16'sd0, FLAG_NONE, 16'h0), 0);
      add_row(mk_req(MODE_STORE, KEY_ALIAS, 8'd0, 16'sd0, 16'sd0, 8'd9, -16'sd31000, FLAG_LOWER,
                     16'hAAAA), 1);
      add_row(mk_req(MODE_PROBE, KEY_ALIAS, 8'd0, 16'sd0, -16'sd32768, 8'd1, 16'sd0, FLAG_NONE,
                     16'h0), 0);
      add_row(mk_req(MODE_CLEAR, KEY_TOP, 8'd0, 16'sd0, 16'sd0, 8'd0, 16'sd0, FLAG_NONE, 16'h0), 1);
      add_row(mk_req(MODE_PROBE, KEY_ALIAS, 8'd0, 16'sd0, 16'sd0, 8'd0, 16'sd0, FLAG_NONE, 16'h0), 1);
      add_row(mk_req(MODE_PROBE, '0, 8'd0, 16'sd0, 16'sd0, 8'd0, 16'sd0, FLAG_NONE, 16'h0), 1);
      add_row(mk_req(MODE_PROBE, '0, 8'd1, 16'sd0, 16'sd0, 8'd0, 16'sd0, FLAG_NONE, 16'h0), 1);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         send_beat(plan[i].item, plan[i].typed, plan[i].want);
      end

      for (int ph = 0; ph < 6; ph++) begin
         wait_idle();
         case (ph / 2)
            0: begin
               gap_pct = 10;
               stall_pct = 59;
            end
            1: begin
               gap_pct = 59;
               stall_pct = 10;
            end
            default: begin
               gap_pct = 0;
               stall_pct = 0;
            end
         endcase
         set_mate_score(mate_plan[ph]);
         refill_keys();
         repeat (PHASE_ITEMS) begin
            send_beat(random_request(), 1'b0, '0);
         end
      end

      wait_idle();
      repeat (16) @(posedge clock);
      $display("ran %0d requests including %0d table clears, %0d probe hits seen", n_requests,
               n_clears, n_hits);
      $display("mate score settings: reset value, 32767, 0, 1000, %0d, 500, 32000", mate_plan[3]);
      if (mismatches == 0 && awaited_results.size() == 0) begin
         $display("direct_mapped_search_result_table_tb: done, clean");
      end else begin
         $display("direct_mapped_search_result_table_tb: done, errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/dmsrt_pkg.sv
hw/rtl/dmsrt_ram.sv
hw/rtl/dmsrt_ctrl.sv
hw/rtl/dmsrt_dpath.sv
hw/rtl/direct_mapped_search_result_table.sv
test/direct_mapped_search_result_table_tb.sv
